/* hw/rtl/lpr_pkg.sv */
// shared constants, types and divider handshake structs for the line rasterizer
package lpr_pkg;

    localparam int COORD_BITS   = 6;
    localparam int COLOR_BITS   = 8;
    localparam int STEP_BITS    = COORD_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(COORD_BITS + 1);
    localparam int IN_DATA_W    = 32;
    localparam int OUT_DATA_W   = 24;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [COLOR_BITS-1:0] color_t;

    // divider launch: operands sampled when start is high
    typedef struct packed {
        logic   start;
        coord_t num;
        coord_t den;
    } div_req_t;

    // divider result: quot and rem valid in the cycle done is high
    typedef struct packed {
        logic   done;
        coord_t quot;
        coord_t rem;
    } div_res_t;

endpackage

/* hw/rtl/lpr_divider.sv */
// iterative restoring divider, one quotient bit per cycle through one subtractor
module lpr_divider (
    input  logic             clk,
    input  logic             rst_n,
    input  lpr_pkg::div_req_t req,
    output lpr_pkg::div_res_t res
);
    import lpr_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    coord_t                  num_reg, num_next;
    coord_t                  den_reg, den_next;
    coord_t                  rem_reg, rem_next;
    logic [COORD_BITS:0]     trial;
    logic [COORD_BITS:0]     diff;

    // shared subtract and compare
    assign trial = {rem_reg, num_reg[COORD_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_BITS'(COORD_BITS - 1);
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[COORD_BITS-1:0];
                num_next = {num_reg[COORD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[COORD_BITS-1:0];
                num_next = {num_reg[COORD_BITS-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign res = '{done: done_reg, quot: num_reg, rem: rem_reg};

endmodule

/* hw/rtl/line_pixel_rasterizer.sv */
// line rasterizer top: endpoint ordering, slope divide sequencing, pixel stepping
// sequencing: a vertical line goes straight to pixel stepping; other lines first run the
//   6-step slope divide plus floor fixup before stepping
// throughput: one pixel word per cycle once stepping, while the sink is ready; the input
//   stays not ready until the last pixel word of the current line is loaded
// reset: asynchronous active low, returns to idle with the output empty
module line_pixel_rasterizer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // start_x, start_y, end_x, end_y, pen_color
    input  logic [lpr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pixel_x, pixel_y, pixel_color, zero pad
    output logic [lpr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // last_pixel
    output logic                          m_axis_tlast
);
    import lpr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // line context
    coord_t                cur_col_reg, cur_col_next;
    coord_t                stop_col_reg, stop_col_next;
    coord_t                cur_row_reg, cur_row_next;
    coord_t                stop_row_reg, stop_row_next;
    coord_t                span_reg, span_next;
    coord_t                frac_acc_reg, frac_acc_next;
    coord_t                step_frac_reg, step_frac_next;
    logic [STEP_BITS-1:0]  step_whole_reg, step_whole_next;
    logic                  vert_reg, vert_next;
    logic                  dy_neg_reg, dy_neg_next;
    color_t                color_reg, color_next;

    // output word register
    logic                  out_valid_reg, out_valid_next;
    coord_t                pix_x_reg, pix_x_next;
    coord_t                pix_y_reg, pix_y_next;
    color_t                pix_color_reg, pix_color_next;
    logic                  pix_last_reg, pix_last_next;

    // incoming word fields
    coord_t                in_x1, in_y1, in_x2, in_y2;
    color_t                in_color;
    coord_t                x1, y1, x2, y2;
    logic                  swap;
    logic                  accept;
    logic                  in_vert;
    logic                  in_dy_neg;
    coord_t                in_dy_mag;

    // stepping
    logic                  load;
    logic                  is_last;
    logic [COORD_BITS:0]   frac_sum;
    logic                  wrap;

    div_req_t              div_req;
    div_res_t              div_res;

    assign in_x1    = s_axis_tdata[COORD_BITS-1:0];
    assign in_y1    = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_x2    = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign in_y2    = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
    assign in_color = s_axis_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // order endpoints so the column runs upward
    assign swap      = in_x1 > in_x2;
    assign x1        = swap ? in_x2 : in_x1;
    assign y1        = swap ? in_y2 : in_y1;
    assign x2        = swap ? in_x1 : in_x2;
    assign y2        = swap ? in_y1 : in_y2;
    assign in_vert   = (x1 == x2);
    assign in_dy_neg = y2 < y1;
    assign in_dy_mag = in_dy_neg ? (y1 - y2) : (y2 - y1);

    // slope divide |dy| / dx, launched as a non-vertical line is taken
    assign div_req = '{start: accept && !in_vert, num: in_dy_mag, den: x2 - x1};

    lpr_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    assign load     = (state_reg == ST_EMIT) && (!out_valid_reg || m_axis_tready);
    assign is_last  = vert_reg ? (cur_row_reg == stop_row_reg)
                               : (cur_col_reg == stop_col_reg);
    assign frac_sum = {1'b0, frac_acc_reg} + {1'b0, step_frac_reg};
    assign wrap     = frac_sum >= {1'b0, span_reg};

    always_comb
    begin
        state_next      = state_reg;
        cur_col_next    = cur_col_reg;
        stop_col_next   = stop_col_reg;
        cur_row_next    = cur_row_reg;
        stop_row_next   = stop_row_reg;
        span_next       = span_reg;
        frac_acc_next   = frac_acc_reg;
        step_frac_next  = step_frac_reg;
        step_whole_next = step_whole_reg;
        vert_next       = vert_reg;
        dy_neg_next     = dy_neg_reg;
        color_next      = color_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        pix_x_next      = pix_x_reg;
        pix_y_next      = pix_y_reg;
        pix_color_next  = pix_color_reg;
        pix_last_next   = pix_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cur_col_next  = x1;
                    stop_col_next = x2;
                    span_next     = x2 - x1;
                    frac_acc_next = '0;
                    vert_next     = in_vert;
                    dy_neg_next   = in_dy_neg;
                    color_next    = in_color;
                    if (in_vert)
                    begin
                        // single column: walk rows from low to high
                        cur_row_next    = in_dy_neg ? y2 : y1;
                        stop_row_next   = in_dy_neg ? y1 : y2;
                        step_whole_next = '0;
                        step_frac_next  = '0;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        cur_row_next  = y1;
                        stop_row_next = y2;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    // turn truncated |dy|/dx into floor division of signed dy
                    if (!dy_neg_reg)
                    begin
                        step_whole_next = {1'b0, div_res.quot};
                        step_frac_next  = div_res.rem;
                    end
                    else if (div_res.rem == '0)
                    begin
                        step_whole_next = ~{1'b0, div_res.quot} + 1'b1;
                        step_frac_next  = '0;
                    end
                    else
                    begin
                        step_whole_next = ~{1'b0, div_res.quot};
                        step_frac_next  = span_reg - div_res.rem;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    pix_x_next     = cur_col_reg;
                    pix_y_next     = cur_row_reg;
                    pix_color_next = color_reg;
                    pix_last_next  = is_last;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (vert_reg)
                    begin
                        cur_row_next = cur_row_reg + 1'b1;
                    end
                    else
                    begin
                        cur_col_next  = cur_col_reg + 1'b1;
                        // row wraps modulo the coordinate range
                        cur_row_next  = cur_row_reg + step_whole_reg[COORD_BITS-1:0]
                                        + COORD_BITS'(wrap);
                        frac_acc_next = wrap ? COORD_BITS'(frac_sum - {1'b0, span_reg})
                                             : frac_sum[COORD_BITS-1:0];
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_col_reg    <= cur_col_next;
        stop_col_reg   <= stop_col_next;
        cur_row_reg    <= cur_row_next;
        stop_row_reg   <= stop_row_next;
        span_reg       <= span_next;
        frac_acc_reg   <= frac_acc_next;
        step_frac_reg  <= step_frac_next;
        step_whole_reg <= step_whole_next;
        vert_reg       <= vert_next;
        dy_neg_reg     <= dy_neg_next;
        color_reg      <= color_next;
        pix_x_reg      <= pix_x_next;
        pix_y_reg      <= pix_y_next;
        pix_color_reg  <= pix_color_next;
        pix_last_reg   <= pix_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = pix_last_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - 2*COORD_BITS - COLOR_BITS)'(0),
                            pix_color_reg, pix_y_reg, pix_x_reg};

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the line rasterizer: directed table, random lines, pixel predictor
module tb_top;

    import lpr_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int MAX_GAP        = 10;
    localparam int RANDOM_LINES   = 300;
    localparam int RX_HOLD_CYCLES = 400;   // long sink stall, input must back up
    localparam int IDLE_LIMIT     = 3000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES   = 100;   // longest line plus divide, with margin
    localparam int MAX_REPORTS    = 10;
    localparam int HOLD_AT_LINE   = 60;    // random line index that triggers the sink stall
    localparam int PAUSE_AT_LINE  = 120;   // random line index where the source drains first
    localparam int BURST_FROM     = 180;   // random lines in this window run with no gaps
    localparam int BURST_TO       = 230;

    // one expected or observed pixel word
    typedef struct packed {
        coord_t x;
        coord_t y;
        color_t color;
        logic   last;
    } pixel_t;

    // directed line; when spelled_out is set the single pixel is written in the row
    typedef struct packed {
        logic   spelled_out;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        color_t color;
        coord_t px;
        coord_t py;
    } line_row_t;

    localparam int NUM_DIRECTED = 17;

    line_row_t directed_lines [NUM_DIRECTED] = '{
        // single points: one pixel, flagged last
        '{1'b1, 6'd0,  6'd0,  6'd0,  6'd0,  8'h00, 6'd0,  6'd0},
        '{1'b1, 6'd63, 6'd63, 6'd63, 6'd63, 8'hFF, 6'd63, 6'd63},
        '{1'b1, 6'd5,  6'd9,  6'd5,  6'd9,  8'hA5, 6'd5,  6'd9},
        // full-width horizontal, forward and with reversed columns
        '{1'b0, 6'd0,  6'd0,  6'd63, 6'd0,  8'h11, 6'd0,  6'd0},
        '{1'b0, 6'd63, 6'd63, 6'd0,  6'd63, 8'hEE, 6'd0,  6'd0},
        // full-height vertical, rows ascending and reversed
        '{1'b0, 6'd0,  6'd0,  6'd0,  6'd63, 8'h3C, 6'd0,  6'd0},
        '{1'b0, 6'd63, 6'd63, 6'd63, 6'd0,  8'hC3, 6'd0,  6'd0},
        // diagonals
        '{1'b0, 6'd0,  6'd0,  6'd63, 6'd63, 8'h5A, 6'd0,  6'd0},
        '{1'b0, 6'd0,  6'd63, 6'd63, 6'd0,  8'hA5, 6'd0,  6'd0},
        // steep lines keep their row gaps, also with swapped endpoints
        '{1'b0, 6'd10, 6'd0,  6'd12, 6'd63, 8'h01, 6'd0,  6'd0},
        '{1'b0, 6'd12, 6'd63, 6'd10, 6'd0,  8'h80, 6'd0,  6'd0},
        '{1'b0, 6'd0,  6'd63, 6'd1,  6'd0,  8'h7F, 6'd0,  6'd0},
        '{1'b0, 6'd1,  6'd0,  6'd0,  6'd63, 8'hFE, 6'd0,  6'd0},
        // shallow and non-integer negative slope
        '{1'b0, 6'd0,  6'd5,  6'd63, 6'd7,  8'h42, 6'd0,  6'd0},
        '{1'b0, 6'd3,  6'd40, 6'd20, 6'd2,  8'h24, 6'd0,  6'd0},
        // alternating bit patterns on every field
        '{1'b0, 6'h2A, 6'h15, 6'h15, 6'h2A, 8'h55, 6'd0,  6'd0},
        '{1'b0, 6'h15, 6'h2A, 6'h2A, 6'h15, 8'hAA, 6'd0,  6'd0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // start_x, start_y, end_x, end_y, pen_color
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // pixel_x, pixel_y, pixel_color, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // last_pixel
    logic                  m_axis_tlast;

    pixel_t pending_pixels [$];
    int     mismatch_count = 0;
    int     idle_cycles = 0;
    bit     no_gaps = 1'b0;
    bit     rx_hold_req = 1'b0;

    line_pixel_rasterizer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic int pick_gap();
        if (no_gaps)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // expected pixels of one line: order endpoints by column, then either walk the
    // rows of a vertical line or step one column at a time with an exact floor slope
    function automatic void plot_line(input coord_t ax, input coord_t ay,
                                      input coord_t bx, input coord_t by,
                                      input color_t color);
        int x1;
        int y1;
        int x2;
        int y2;
        int t;
        int dx;
        int dy;
        int whole;
        int rem;
        int acc;
        int row;
        x1 = ax;
        y1 = ay;
        x2 = bx;
        y2 = by;
        if (x1 > x2)
        begin
            t = x1; x1 = x2; x2 = t;
            t = y1; y1 = y2; y2 = t;
        end
        if (x1 == x2)
        begin
            if (y1 > y2)
            begin
                t = y1; y1 = y2; y2 = t;
            end
            for (int r = y1; r <= y2; r++)
                pending_pixels.push_back('{coord_t'(x1), coord_t'(r), color, r == y2});
        end
        else
        begin
            dx = x2 - x1;
            dy = y2 - y1;
            // floor division, dx is always positive here
            if (dy >= 0)
                whole = dy / dx;
            else
                whole = -((-dy + dx - 1) / dx);
            rem = dy - whole * dx;
            acc = 0;
            row = y1;
            for (int c = x1; c <= x2; c++)
            begin
                pending_pixels.push_back('{coord_t'(c), coord_t'(row), color, c == x2});
                row = row + whole;
                acc = acc + rem;
                if (acc >= dx)
                begin
                    acc = acc - dx;
                    row = row + 1;
                end
                row = row & ((1 << COORD_BITS) - 1);
            end
        end
    endfunction

    // offer one line word after a random gap, hold it until taken, then queue its pixels
    task automatic send_line(input line_row_t ln);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  = {ln.color, ln.ey, ln.ex, ln.sy, ln.sx};
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (ln.spelled_out)
            pending_pixels.push_back('{ln.px, ln.py, ln.color, 1'b1});
        else
            plot_line(ln.sx, ln.sy, ln.ex, ln.ey, ln.color);
        @(negedge clk);
    endtask

    // random line: mostly general, with vertical, single point and short lines mixed in
    function automatic line_row_t random_line();
        line_row_t ln;
        int kind;
        int span;
        kind = $urandom_range(0, 9);
        ln.spelled_out = 1'b0;
        ln.px = '0;
        ln.py = '0;
        ln.color = color_t'($urandom_range(0, 255));
        ln.sx = coord_t'($urandom_range(0, 63));
        ln.sy = coord_t'($urandom_range(0, 63));
        ln.ex = coord_t'($urandom_range(0, 63));
        ln.ey = coord_t'($urandom_range(0, 63));
        case (kind)
            6: ln.ex = ln.sx;
            7:
            begin
                ln.ex = ln.sx;
                ln.ey = ln.sy;
            end
            8, 9:
            begin
                // short segment near the start point, clamped to the grid
                span = $urandom_range(0, 7);
                ln.ex = coord_t'((ln.sx + span > 63) ? 63 : ln.sx + span);
                if ($urandom_range(0, 1) == 1)
                begin
                    ln.ex = ln.sx;
                    ln.sx = coord_t'((ln.ex + span > 63) ? 63 : ln.ex + span);
                end
                ln.ey = coord_t'($urandom_range(0, 63));
            end
            default: ;
        endcase
        return ln;
    endfunction

    // pixel sink: random ready gaps, one long stall on request, field checks
    initial
    begin : pixel_sink
        int     gap;
        pixel_t got;
        pixel_t want;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            if (rx_hold_req)
            begin
                m_axis_tready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                rx_hold_req = 1'b0;
            end
            m_axis_tready = 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            got = '{m_axis_tdata[5:0], m_axis_tdata[11:6], m_axis_tdata[19:12], m_axis_tlast};
            if (pending_pixels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected pixel word: x=%0d y=%0d color=%02h last=%0b",
                             got.x, got.y, got.color, got.last);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
                    got.last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("pixel mismatch: exp %0d,%0d,%02h,%0b got %0d,%0d,%02h,%0b",
                                 want.x, want.y, want.color, want.last,
                                 got.x, got.y, got.color, got.last);
                end
            end
        end
    end

    // watchdog: no word moving on either side for too long ends the run
    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : line_source
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_line(directed_lines[i]);

        for (int i = 0; i < RANDOM_LINES; i++)
        begin
            no_gaps = (i >= BURST_FROM && i < BURST_TO);
            // sink stalls for a long stretch while lines keep coming
            if (i == HOLD_AT_LINE)
                rx_hold_req = 1'b1;
            // let everything drain before going on
            if (i == PAUSE_AT_LINE)
            begin
                s_axis_tvalid = 1'b0;
                while (pending_pixels.size() != 0)
                    @(negedge clk);
            end
            send_line(random_line());
        end
        s_axis_tvalid = 1'b0;
        no_gaps = 1'b0;

        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
